/* design/rus_pkg.sv */
// Shared types and constants for the RGB 2x upscaler with 3x3 smoothing.
package rus_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CFG_W         = 11;
  localparam int COL_OUT_W     = 11;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = CFG_W'(512);

  typedef logic [7:0] chan_t;
  // [0] red, [1] green, [2] blue
  typedef chan_t [2:0] rgb_t;
  // [0] oldest column of the window
  typedef rgb_t [2:0] win_row_t;
  // [0] line before previous, [1] previous line, [2] current line
  typedef win_row_t [2:0] win_t;

  typedef struct packed {
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
    logic  frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] out_column;
    chan_t                top_red;
    chan_t                top_green;
    chan_t                top_blue;
    chan_t                bottom_red;
    chan_t                bottom_green;
    chan_t                bottom_blue;
    logic                 pair_done;
  } pair_out_t;

  // Which output column of a pixel's group is produced
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_LAST_EVEN,
    PH_LAST_ODD
  } phase_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] column;
    logic                 border;
    logic                 pair_done;
  } flt_meta_t;

endpackage

/* design/rus_stream_if.sv */
// Valid/ready stream channel carrying one payload per transaction.
interface rus_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/rus_filter.sv */
// Filter pipeline: column interpolation, line averaging, 3x3 kernel and divide by 42.
module rus_filter
  import rus_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      issue_valid,
  input  win_t      issue_win,
  input  phase_t    issue_phase,
  input  flt_meta_t issue_meta,
  output logic      res_valid,
  output pair_out_t res_data
);

  localparam int SUM_W      = 14;
  localparam int KERNEL_SUM = 42;
  localparam int DIV_SHIFT  = 20;
  localparam int DIV_MULT   = ((1 << DIV_SHIFT) + KERNEL_SUM - 1) / KERNEL_SUM;
  localparam int MULT_W     = $clog2(DIV_MULT + 1);
  localparam int PROD_W     = SUM_W + MULT_W;

  typedef chan_t [2:0]       dcol_t;    // three doubled-width columns
  typedef dcol_t [3:0]       dlines_t;  // four doubled lines
  typedef logic [SUM_W-1:0]  sum_t;

  dlines_t [2:0] dbl_nxt;
  dlines_t [2:0] dbl_r;
  logic          a_valid_r;
  flt_meta_t     a_meta_r;

  sum_t [2:0]    top_sum_nxt;
  sum_t [2:0]    bot_sum_nxt;
  sum_t [2:0]    top_sum_r;
  sum_t [2:0]    bot_sum_r;
  logic          b_valid_r;
  flt_meta_t     b_meta_r;

  chan_t [2:0]   top_q;
  chan_t [2:0]   bot_q;

  function automatic chan_t avg2(input chan_t a, input chan_t b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  function automatic sum_t times3(input chan_t x);
    return (sum_t'(x) << 1) + sum_t'(x);
  endfunction

  function automatic sum_t times5(input chan_t x);
    return (sum_t'(x) << 2) + sum_t'(x);
  endfunction

  // kernel 3,5,3 / 5,10,5 / 3,5,3 over three doubled lines
  function automatic sum_t kern(input dcol_t up, input dcol_t mid, input dcol_t low);
    return times3(up[0]) + times5(up[1]) + times3(up[2])
         + times5(mid[0]) + (times5(mid[1]) << 1) + times5(mid[2])
         + times3(low[0]) + times5(low[1]) + times3(low[2]);
  endfunction

  // reciprocal multiply, exact for sums up to 42*255
  function automatic chan_t div42(input sum_t s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(DIV_MULT);
    return p[DIV_SHIFT +: 8];
  endfunction

  // Stage A: horizontal interpolation, then vertical averaging
  always_comb begin
    dcol_t [2:0] h;
    chan_t       m01;
    chan_t       m12;
    h   = '0;
    m01 = '0;
    m12 = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int ln = 0; ln < 3; ln++) begin
        m01 = avg2(issue_win[ln][0][ch], issue_win[ln][1][ch]);
        m12 = avg2(issue_win[ln][1][ch], issue_win[ln][2][ch]);
        case (issue_phase)
          PH_FIRST: begin
            h[ln][0] = m01;
            h[ln][1] = issue_win[ln][1][ch];
            h[ln][2] = m12;
          end
          PH_LAST_EVEN: begin
            // last column repeats the last pixel
            h[ln][0] = m12;
            h[ln][1] = issue_win[ln][2][ch];
            h[ln][2] = issue_win[ln][2][ch];
          end
          default: begin
            h[ln][0] = issue_win[ln][1][ch];
            h[ln][1] = m12;
            h[ln][2] = issue_win[ln][2][ch];
          end
        endcase
      end
      for (int j = 0; j < 3; j++) begin
        dbl_nxt[ch][0][j] = avg2(h[0][j], h[1][j]);
        dbl_nxt[ch][1][j] = h[1][j];
        dbl_nxt[ch][2][j] = avg2(h[1][j], h[2][j]);
        dbl_nxt[ch][3][j] = h[2][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= issue_valid;
    end
    if (en) begin
      dbl_r    <= dbl_nxt;
      a_meta_r <= issue_meta;
    end
  end

  // Stage B: weighted sums, upper row over lines 0..2, lower row over 1..3
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      top_sum_nxt[ch] = kern(dbl_r[ch][0], dbl_r[ch][1], dbl_r[ch][2]);
      bot_sum_nxt[ch] = kern(dbl_r[ch][1], dbl_r[ch][2], dbl_r[ch][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
    if (en) begin
      top_sum_r <= top_sum_nxt;
      bot_sum_r <= bot_sum_nxt;
      b_meta_r  <= a_meta_r;
    end
  end

  // Stage C: divide; output buffer in the top level registers it
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      top_q[ch] = b_meta_r.border ? '0 : div42(top_sum_r[ch]);
      bot_q[ch] = b_meta_r.border ? '0 : div42(bot_sum_r[ch]);
    end
  end

  assign res_valid              = b_valid_r;
  assign res_data.out_column    = b_meta_r.column;
  assign res_data.top_red       = top_q[0];
  assign res_data.top_green     = top_q[1];
  assign res_data.top_blue      = top_q[2];
  assign res_data.bottom_red    = bot_q[0];
  assign res_data.bottom_green  = bot_q[1];
  assign res_data.bottom_blue   = bot_q[2];
  assign res_data.pair_done     = b_meta_r.pair_done;

endmodule

/* design/rgb_upscale2x_lowpass3x3.sv */
// Path: a pixel passes S1, the window, filter stages A and B and the output register.
// Throughput: one result per cycle through the filter pipeline unless the skid is full;
//   a pixel gives 2 results, the last pixel of a line 4, first-line and column-0 pixels 0.
// Reset (rst_n low, synchronous) clears control state and sets line_width to 512;
//   the two line stores are not cleared, the first line of each frame fills them.
module rgb_upscale2x_lowpass3x3
  import rus_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  rus_stream_if.sink       in_chan,
  rus_stream_if.source     out_chan,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam logic [2:0] JOB_NONE     = 3'd0;
  localparam logic [2:0] JOB_PAIR     = 3'd2;
  localparam logic [2:0] JOB_LINE_END = 3'd4;

  typedef logic [COL_W-1:0] col_t;

  // configuration and counters
  logic [CFG_W-1:0] line_width_r;
  logic [31:0]      wd_full;
  col_t             last_col;
  col_t             col_r;
  col_t             col_nxt;
  logic             primed_r;
  logic             primed_nxt;

  // input side
  pix_in_t          in_d;
  logic             in_fire;
  col_t             in_col;
  logic             in_primed;

  // read/modify/write stage
  logic             s1_valid_r;
  rgb_t             s1_pix_r;
  col_t             s1_col_r;
  logic             s1_prime_r;
  logic             s1_go;
  rgb_t             older_wdata;

  rgb_t             older_mem [MAX_WIDTH];
  rgb_t             newer_mem [MAX_WIDTH];
  rgb_t             older_rd_r;
  rgb_t             newer_rd_r;

  // window and result sequencer
  win_t             win_r;
  logic [2:0]       job_left_r;
  phase_t           job_phase_r;
  col_t             job_col_r;
  logic             job_free;
  logic             issue;
  col_t             base_col;
  logic             odd_col;
  logic [31:0]      col_full;
  flt_meta_t        issue_meta;

  // filter and output buffer
  logic             pipe_en;
  logic             res_valid;
  pair_out_t        res_data;
  logic             push;
  logic             out_fire;
  logic             out_valid_r;
  logic             skid_valid_r;
  pair_out_t        out_data_r;
  pair_out_t        skid_data_r;

  // effective width clamped to 2..MAX_WIDTH
  always_comb begin
    if (line_width_r < CFG_W'(2)) begin
      wd_full = 32'd2;
    end else if (32'(line_width_r) > 32'(MAX_WIDTH)) begin
      wd_full = 32'(MAX_WIDTH);
    end else begin
      wd_full = 32'(line_width_r);
    end
  end
  assign last_col = COL_W'(wd_full - 32'd1);

  assign in_d      = in_chan.data;
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign in_col    = in_d.frame_start ? '0 : col_r;
  assign in_primed = !in_d.frame_start && primed_r;

  assign col_nxt    = (in_col == last_col) ? '0 : in_col + COL_W'(1);
  assign primed_nxt = (in_col == last_col) || in_primed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      col_r        <= '0;
      primed_r     <= 1'b0;
    end else if (cfg_we) begin
      // a width change restarts the frame
      line_width_r <= cfg_wdata;
      col_r        <= '0;
      primed_r     <= 1'b0;
    end else if (in_fire) begin
      col_r    <= col_nxt;
      primed_r <= primed_nxt;
    end
  end

  // S1 waits here until the window is free; read data holds meanwhile
  assign s1_go         = s1_valid_r && (s1_prime_r || job_free);
  assign in_chan.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
    if (in_fire) begin
      s1_pix_r   <= {in_d.blue_in, in_d.green_in, in_d.red_in};
      s1_col_r   <= in_col;
      s1_prime_r <= !in_primed;
    end
  end

  // Line stores: read at accept, write back when S1 retires. A read never hits
  // the entry written in the same cycle since consecutive columns differ.
  assign older_wdata = s1_prime_r ? s1_pix_r : newer_rd_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      older_mem[s1_col_r] <= older_wdata;
      newer_mem[s1_col_r] <= s1_pix_r;
    end
    if (in_fire) begin
      older_rd_r <= older_mem[in_col];
      newer_rd_r <= newer_mem[in_col];
    end
  end

  // window shift on each non-priming pixel
  always_ff @(posedge clk) begin
    if (s1_go && !s1_prime_r) begin
      for (int ln = 0; ln < 3; ln++) begin
        win_r[ln][0] <= win_r[ln][1];
        win_r[ln][1] <= win_r[ln][2];
      end
      win_r[0][2] <= older_rd_r;
      win_r[1][2] <= newer_rd_r;
      win_r[2][2] <= s1_pix_r;
    end
  end

  assign issue    = (job_left_r != JOB_NONE) && pipe_en;
  assign job_free = (job_left_r == JOB_NONE) || (job_left_r == 3'd1 && issue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_left_r <= JOB_NONE;
    end else if (s1_go && !s1_prime_r) begin
      if (s1_col_r == '0) begin
        job_left_r <= JOB_NONE;
      end else if (s1_col_r == last_col) begin
        job_left_r <= JOB_LINE_END;
      end else begin
        job_left_r <= JOB_PAIR;
      end
    end else if (issue) begin
      job_left_r <= job_left_r - 3'd1;
    end
    if (s1_go && !s1_prime_r) begin
      job_phase_r <= PH_FIRST;
      job_col_r   <= s1_col_r;
    end else if (issue) begin
      job_phase_r <= phase_t'(job_phase_r + 2'd1);
    end
  end

  // output column: 2c-2, 2c-1, then 2w-2, 2w-1 at the end of a line
  always_comb begin
    if (job_phase_r == PH_FIRST || job_phase_r == PH_SECOND) begin
      base_col = job_col_r - COL_W'(1);
    end else begin
      base_col = last_col;
    end
    odd_col  = (job_phase_r == PH_SECOND) || (job_phase_r == PH_LAST_ODD);
    col_full = 32'({base_col, odd_col});
    issue_meta.column    = col_full[COL_OUT_W-1:0];
    issue_meta.border    = (job_phase_r == PH_LAST_ODD)
                        || (job_phase_r == PH_FIRST && job_col_r == COL_W'(1));
    issue_meta.pair_done = (job_phase_r == PH_LAST_ODD);
  end

  rus_filter u_filter (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (pipe_en),
    .issue_valid (issue),
    .issue_win   (win_r),
    .issue_phase (job_phase_r),
    .issue_meta  (issue_meta),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  // output register plus skid entry; the pipeline stalls only on a full skid
  assign pipe_en  = !skid_valid_r;
  assign push     = pipe_en && res_valid;
  assign out_fire = out_valid_r && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && (!out_valid_r || out_fire)) begin
      out_data_r <= res_data;
    end else if (push) begin
      skid_data_r <= res_data;
    end else if (out_fire && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

/* design/rus_checker.sv */
// Port-level checker for the upscaler result stream, bound to the top level.
module rus_checker
  import rus_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input pair_out_t out_data
);

  logic                 after_done_r;
  logic [COL_OUT_W-1:0] prev_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_done_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      after_done_r <= out_data.pair_done;
    end
    if (out_valid && out_ready) begin
      prev_col_r <= out_data.out_column;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_pair_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && after_done_r |-> out_data.out_column == '0)
    else $error("row pair does not start at column zero");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !after_done_r
      |-> out_data.out_column == prev_col_r + COL_OUT_W'(1) || out_data.out_column == '0)
    else $error("output column skipped or repeated");

endmodule

bind rgb_upscale2x_lowpass3x3 rus_checker u_rus_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
